### rtl/yrp_pkg.sv
// ----------------------------------------------------------------------------
// yrp_pkg
// Shared types, format codes and chroma lookup tables for the 4:2:2 macropixel
// to RGB888 pair converter.
// ----------------------------------------------------------------------------
package yrp_pkg;

  typedef enum logic [1:0] {
    FMT_YUYV = 2'd0,
    FMT_UYVY = 2'd1,
    FMT_NV12 = 2'd2
  } pixel_fmt_t;

  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Luma samples of both pixel lanes and the chroma contributions they share
  typedef struct packed {
    logic [7:0]        y0;
    logic [7:0]        y1;
    logic signed [8:0] dr;
    logic signed [8:0] dg;
    logic signed [8:0] db;
  } chroma_out_t;

  localparam longint COEF_SCALE = 64'd1000000;
  localparam longint COEF_RV    = 64'd1402000;
  localparam longint COEF_BU    = 64'd1772000;
  localparam int     CHROMA_BIAS = 128;

  // Green path works on coefficients and divisor scaled down by 8 (exact)
  localparam logic signed [17:0] GU_K     = 18'sd43017;
  localparam logic signed [17:0] GV_K     = 18'sd89267;
  localparam logic [16:0]        G_DIV    = 17'd125000;
  // floor(2^24 / 125000): quotient estimate is exact or one low
  localparam logic [7:0]         G_RECIP  = 8'd134;
  localparam int                 G_SHIFT  = 24;

  typedef logic signed [8:0] delta_tab_t [256];

  // trunc(coef * (b - 128) / 10^6) for every chroma byte b
  function automatic delta_tab_t build_tab(input longint coef);
    delta_tab_t tab;
    longint     num;
    for (int i = 0; i < 256; i++) begin
      num = coef * longint'(i - CHROMA_BIAS);
      if (num < 0) begin
        tab[i] = 9'(-((-num) / COEF_SCALE));
      end else begin
        tab[i] = 9'(num / COEF_SCALE);
      end
    end
    return tab;
  endfunction

  localparam delta_tab_t DR_TAB = build_tab(COEF_RV);
  localparam delta_tab_t DB_TAB = build_tab(COEF_BU);

endpackage

### rtl/yrp_chroma.sv
// ----------------------------------------------------------------------------
// yrp_chroma
// Four-stage front end: byte-order decode, chroma table lookups and green
// product sum, reciprocal quotient estimate, quotient correction.
// ----------------------------------------------------------------------------
module yrp_chroma (
  input  logic                clk,
  input  logic                rst_n,
  input  yrp_pkg::pixel_fmt_t fmt,
  input  logic                in_valid,
  input  yrp_pkg::in_item_t   in_data,
  output logic                in_ready,
  output logic                out_valid,
  output yrp_pkg::chroma_out_t out_data,
  input  logic                out_ready
);
  import yrp_pkg::*;

  logic valid1_r, valid2_r, valid3_r, valid4_r;
  logic ready1, ready2, ready3, ready4;

  logic [7:0] s1_y0_r, s1_y1_r, s1_ub_r, s1_vb_r;
  logic [7:0] y0_dec, y1_dec, ub_dec, vb_dec;

  logic [7:0]        s2_y0_r, s2_y1_r;
  logic signed [8:0] s2_dr_r, s2_db_r;
  logic              s2_neg_r;
  logic [24:0]       s2_mag_r;
  logic signed [8:0] u_s, v_s;
  logic signed [26:0] gsum;

  logic [7:0]        s3_y0_r, s3_y1_r;
  logic signed [8:0] s3_dr_r, s3_db_r;
  logic              s3_neg_r;
  logic [24:0]       s3_mag_r;
  logic [7:0]        s3_q_r;
  logic [32:0]       qprod;

  logic [7:0]        s4_y0_r, s4_y1_r;
  logic signed [8:0] s4_dr_r, s4_db_r, s4_dg_r;
  logic [24:0]       rem;
  logic [7:0]        q_fix;

  // A stage loads when empty or when its contents move on
  assign ready4   = !valid4_r || out_ready;
  assign ready3   = !valid3_r || ready4;
  assign ready2   = !valid2_r || ready3;
  assign ready1   = !valid1_r || ready2;
  assign in_ready = ready1;

  always_comb begin
    unique case (fmt)
      FMT_UYVY: begin
        ub_dec = in_data.byte_zero;
        y0_dec = in_data.byte_one;
        vb_dec = in_data.byte_two;
        y1_dec = in_data.byte_three;
      end
      FMT_NV12: begin
        y0_dec = in_data.byte_zero;
        y1_dec = in_data.byte_one;
        ub_dec = in_data.byte_two;
        vb_dec = in_data.byte_three;
      end
      default: begin
        // unused code decodes as YUYV
        y0_dec = in_data.byte_zero;
        ub_dec = in_data.byte_one;
        y1_dec = in_data.byte_two;
        vb_dec = in_data.byte_three;
      end
    endcase
  end

  assign u_s  = $signed({1'b0, s1_ub_r}) - $signed(9'd128);
  assign v_s  = $signed({1'b0, s1_vb_r}) - $signed(9'd128);
  assign gsum = GU_K * u_s + GV_K * v_s;

  assign qprod = s2_mag_r * G_RECIP;

  assign rem   = s3_mag_r - 25'(s3_q_r) * 25'(G_DIV);
  assign q_fix = (rem >= 25'(G_DIV)) ? s3_q_r + 8'd1 : s3_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_r <= in_valid;
      end
      if (ready2) begin
        valid2_r <= valid1_r;
      end
      if (ready3) begin
        valid3_r <= valid2_r;
      end
      if (ready4) begin
        valid4_r <= valid3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_y0_r <= y0_dec;
      s1_y1_r <= y1_dec;
      s1_ub_r <= ub_dec;
      s1_vb_r <= vb_dec;
    end
    if (ready2) begin
      s2_y0_r  <= s1_y0_r;
      s2_y1_r  <= s1_y1_r;
      s2_dr_r  <= DR_TAB[s1_vb_r];
      s2_db_r  <= DB_TAB[s1_ub_r];
      s2_neg_r <= gsum[26];
      s2_mag_r <= gsum[26] ? 25'(-gsum) : 25'(gsum);
    end
    if (ready3) begin
      s3_y0_r  <= s2_y0_r;
      s3_y1_r  <= s2_y1_r;
      s3_dr_r  <= s2_dr_r;
      s3_db_r  <= s2_db_r;
      s3_neg_r <= s2_neg_r;
      s3_mag_r <= s2_mag_r;
      s3_q_r   <= qprod[G_SHIFT+7:G_SHIFT];
    end
    if (ready4) begin
      s4_y0_r <= s3_y0_r;
      s4_y1_r <= s3_y1_r;
      s4_dr_r <= s3_dr_r;
      s4_db_r <= s3_db_r;
      // apply sign after truncating the magnitude
      s4_dg_r <= s3_neg_r ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    end
  end

  assign out_valid   = valid4_r;
  assign out_data.y0 = s4_y0_r;
  assign out_data.y1 = s4_y1_r;
  assign out_data.dr = s4_dr_r;
  assign out_data.dg = s4_dg_r;
  assign out_data.db = s4_db_r;

endmodule

### rtl/yrp_lane.sv
// ----------------------------------------------------------------------------
// yrp_lane
// One pixel lane: add the red and blue chroma contributions to a luma sample,
// subtract the green one, and clamp each component to 0..255.
// ----------------------------------------------------------------------------
module yrp_lane (
  input  logic [7:0]        luma,
  input  logic signed [8:0] dr,
  input  logic signed [8:0] dg,
  input  logic signed [8:0] db,
  output yrp_pkg::pixel_t   pix
);
  import yrp_pkg::*;

  logic signed [10:0] y_s, r_s, g_s, b_s;

  function automatic logic [7:0] clamp_pix(input logic signed [10:0] c);
    logic [7:0] res;
    priority if (c < 0) begin
      res = 8'd0;
    end else if (c > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = c[7:0];
    end
    return res;
  endfunction

  assign y_s = $signed({3'b000, luma});
  assign r_s = y_s + {{2{dr[8]}}, dr};
  assign g_s = y_s - {{2{dg[8]}}, dg};
  assign b_s = y_s + {{2{db[8]}}, db};

  assign pix.red   = clamp_pix(r_s);
  assign pix.green = clamp_pix(g_s);
  assign pix.blue  = clamp_pix(b_s);

endmodule

### rtl/yuv422_to_rgb_pair_unit.sv
// An accepted input transaction passes the four front-end stage registers and
// the output register before out_valid. Throughput: one macropixel per cycle
// while out_stall is low; each stage holds one transaction and advances independently.
// Reset (synchronous, rst_n low) empties the pipeline and sets the format
// register to YUYV.
// ----------------------------------------------------------------------------
// yuv422_to_rgb_pair_unit
// BT.601 full-range 4:2:2 macropixel to two RGB888 pixels, one lane per pixel.
// ----------------------------------------------------------------------------
module yuv422_to_rgb_pair_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  yrp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output yrp_pkg::out_item_t out_data
);
  import yrp_pkg::*;

  pixel_fmt_t  fmt_r;
  logic        front_ready;
  logic        chroma_valid;
  chroma_out_t chroma;
  pixel_t      pix_first, pix_second;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        out_ready;

  assign out_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_YUYV;
    end else if (cfg_we) begin
      fmt_r <= pixel_fmt_t'(cfg_wdata);
    end
  end

  yrp_chroma u_chroma (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (front_ready),
    .out_valid (chroma_valid),
    .out_data  (chroma),
    .out_ready (out_ready)
  );

  yrp_lane u_lane_first (
    .luma (chroma.y0),
    .dr   (chroma.dr),
    .dg   (chroma.dg),
    .db   (chroma.db),
    .pix  (pix_first)
  );

  yrp_lane u_lane_second (
    .luma (chroma.y1),
    .dr   (chroma.dr),
    .dg   (chroma.dg),
    .db   (chroma.db),
    .pix  (pix_second)
  );

  // Merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= chroma_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data_r.red_first    <= pix_first.red;
      out_data_r.green_first  <= pix_first.green;
      out_data_r.blue_first   <= pix_first.blue;
      out_data_r.red_second   <= pix_second.red;
      out_data_r.green_second <= pix_second.green;
      out_data_r.blue_second  <= pix_second.blue;
    end
  end

  assign in_stall  = !front_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
